// ===== src/qprs_pkg.sv =====
// qprs_pkg: shared types and constants for the qword pattern replace scanner
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package qprs_pkg;

    localparam int BYTE_W     = 8;
    localparam int WIN        = 8;                 // window length in bytes
    localparam int WIN_IDX_W  = $clog2(WIN);       // index into the window
    localparam int WIN_CNT_W  = $clog2(WIN + 1);   // count of bytes in the window
    localparam int SKIP_AFTER = 7;                 // positions skipped after a match
    localparam int SKIP_W     = 3;
    localparam int POS_W      = 16;
    localparam int CNT_W      = 14;
    localparam int WORD_W     = WIN * BYTE_W;
    localparam int CFG_IDX_W  = 8;
    localparam int MAX_LEN_DEF = 65536;

    localparam logic [CNT_W-1:0] COUNT_CAP = {CNT_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_WORD       = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_WORD = CFG_IDX_W'(1);

    typedef logic [BYTE_W-1:0] byte_t;

    // drain row status seen by the output stage
    typedef struct packed {
        logic empty;
        logic head_last;
    } qprs_drain_stat_t;

endpackage

// ===== src/qprs_cell.sv =====
// qprs_cell: one byte cell of the sliding window row
// depends on qprs_pkg
`timescale 1ns / 1ps

module qprs_cell
    import qprs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  adv,       // a beat is taken this cycle
    input  logic  clr,       // end of buffer, return to zero
    input  logic  rep_en,    // overwrite with the replacement byte
    input  byte_t shift_in,  // byte from the upper neighbor
    input  byte_t pat,
    input  byte_t rep,
    output byte_t data,
    output byte_t nxt,       // value after this step, before end-of-buffer clear
    output logic  hit
);

    byte_t data_reg;
    byte_t data_next;

    assign hit  = (shift_in == pat);
    assign nxt  = rep_en ? rep : shift_in;
    assign data = data_reg;

    always_comb
    begin
        data_next = data_reg;
        if (adv)
        begin
            data_next = clr ? '0 : nxt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== src/qprs_drain.sv =====
// qprs_drain: row of cells that holds the window bytes flushed at end of buffer
// depends on qprs_pkg
`timescale 1ns / 1ps

module qprs_drain
    import qprs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  byte_t [WIN-1:0]      load_bytes,  // window, oldest byte at index 0
    input  logic [WIN_CNT_W-1:0] load_cnt,    // bytes of the window that are real
    input  logic                 pop,
    output byte_t                head_byte,
    output qprs_drain_stat_t     stat
);

    byte_t [WIN-1:0]   byte_reg;
    byte_t [WIN-1:0]   byte_next;
    logic  [WIN-1:0]   vld_reg;
    logic  [WIN-1:0]   vld_next;
    logic  [WIN_CNT_W-1:0] off;
    logic  [WIN_CNT_W-1:0] src;

    // real bytes sit at the top of the window; move them down to index 0
    assign off = WIN_CNT_W'(WIN) - load_cnt;

    always_comb
    begin
        byte_next = byte_reg;
        vld_next  = vld_reg;
        src       = '0;
        if (load)
        begin
            for (int j = 0; j < WIN; j++)
            begin
                src          = WIN_CNT_W'(j) + off;
                byte_next[j] = (src < WIN_CNT_W'(WIN)) ? load_bytes[src[WIN_IDX_W-1:0]] : '0;
                vld_next[j]  = (WIN_CNT_W'(j) < load_cnt);
            end
        end
        else if (pop)
        begin
            for (int j = 0; j < WIN - 1; j++)
            begin
                byte_next[j] = byte_reg[j+1];
                vld_next[j]  = vld_reg[j+1];
            end
            vld_next[WIN-1] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign head_byte      = byte_reg[0];
    assign stat.empty     = !vld_reg[0];
    assign stat.head_last = vld_reg[0] && !vld_reg[1];

endmodule

// ===== src/qword_pattern_replace_scanner_top.sv =====
// qword_pattern_replace_scanner_top: byte stream scanner that replaces 64-bit patterns
// depends on qprs_pkg, qprs_cell, qprs_drain
`timescale 1ns / 1ps

// The block takes one byte per beat on the s_ side and keeps the last eight in
// a row of byte cells. Once eight bytes are in, each new beat compares the window
// (oldest byte least significant) with match_word; a hit overwrites the window
// with replacement_word and the next seven positions are not compared, so hits
// never overlap. A byte leaves on the m_ side once the window has moved past it,
// seven positions late. The beat with tlast flushes the window into a drain row:
// the remaining bytes (all of them for a buffer of fewer than eight bytes) follow
// one per cycle while m_tready allows, and the final one carries the replacement
// count (saturating at 16383), the offset of the first hit and the found flag.
// While streaming the block takes one beat per clock, held up only by m_tready;
// after a tlast beat it takes no beat until the drain row is empty. The output
// register takes a new beat in the same cycle that the previous result leaves;
// while a result waits for m_tready the input waits too. Configuration must be
// written through cfg_* only while the block is idle; the block itself does not
// enforce this.

module qword_pattern_replace_scanner_top
    import qprs_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] in_byte
    input  logic                 s_tlast,   // in_last
    // output stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [39:0]          m_tdata,   // [7:0] out_byte, [21:8] replaced_total,
                                            // [37:22] first_offset, [38] found, [39] zero
    output logic                 m_tlast    // out_last
);

    // position saturates at the smaller of MAX_LEN-1 and the 16-bit limit
    localparam logic [POS_W-1:0] POS_CAP =
        (MAX_LEN - 1 < (1 << POS_W) - 1) ? POS_W'(MAX_LEN - 1) : {POS_W{1'b1}};

    // configuration registers
    logic [WORD_W-1:0] match_reg;
    logic [WORD_W-1:0] repl_reg;

    // scan state
    logic [POS_W-1:0]  pos_reg,   pos_next;
    logic [SKIP_W-1:0] skip_reg,  skip_next;
    logic [CNT_W-1:0]  cnt_reg,   cnt_next;
    logic [POS_W-1:0]  first_reg, first_next;
    logic              seen_reg,  seen_next;

    // end-of-buffer statistics handed to the last output beat
    logic [CNT_W-1:0]  st_cnt_reg;
    logic [POS_W-1:0]  st_first_reg;
    logic              st_found_reg;

    // output register
    logic              ovld_reg, ovld_next;
    byte_t             obyte_reg, obyte_next;
    logic              olast_reg, olast_next;
    logic [CNT_W-1:0]  ocnt_reg, ocnt_next;
    logic [POS_W-1:0]  ofirst_reg, ofirst_next;
    logic              ofound_reg, ofound_next;

    // window row
    byte_t [WIN-1:0]   cell_data;
    byte_t [WIN-1:0]   cell_nxt;
    logic  [WIN-1:0]   cell_hit;

    logic              in_fire;
    logic              full_win;    // window holds eight real bytes after this beat
    logic              do_cmp;
    logic              hit;
    logic              out_free;
    logic [WIN_CNT_W-1:0] flush_cnt;

    byte_t             drain_head;
    qprs_drain_stat_t  drain_stat;
    logic              drain_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= '0;
            repl_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MATCH_WORD:       match_reg <= cfg_data;
                REG_REPLACEMENT_WORD: repl_reg  <= cfg_data;
                default:              ;
            endcase
        end
    end

    // handshake: new beats wait while the drain row holds bytes or the output waits
    assign out_free = !ovld_reg || m_tready;
    assign s_tready = drain_stat.empty && out_free;
    assign in_fire  = s_tvalid && s_tready;

    // compare decision for this beat
    assign full_win = (pos_reg >= POS_W'(WIN - 1));
    assign do_cmp   = full_win && (skip_reg == '0);
    assign hit      = do_cmp && (&cell_hit);

    // row of window cells, data moves toward index 0 each beat
    for (genvar k = 0; k < WIN; k++)
    begin : g_cell
        byte_t shift_in;
        if (k == WIN - 1)
        begin : g_top
            assign shift_in = s_tdata;
        end
        else
        begin : g_mid
            assign shift_in = cell_data[k+1];
        end

        qprs_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (in_fire),
            .clr      (s_tlast),
            .rep_en   (hit),
            .shift_in (shift_in),
            .pat      (match_reg[k*BYTE_W +: BYTE_W]),
            .rep      (repl_reg[k*BYTE_W +: BYTE_W]),
            .data     (cell_data[k]),
            .nxt      (cell_nxt[k]),
            .hit      (cell_hit[k])
        );
    end

    // a short buffer flushes only the bytes it has
    assign flush_cnt = full_win ? WIN_CNT_W'(WIN) : WIN_CNT_W'(pos_reg[WIN_IDX_W-1:0]) + 1'b1;

    // scan state update
    always_comb
    begin
        pos_next   = pos_reg;
        skip_next  = skip_reg;
        cnt_next   = cnt_reg;
        first_next = first_reg;
        seen_next  = seen_reg;
        if (in_fire)
        begin
            if (hit)
            begin
                skip_next = SKIP_W'(SKIP_AFTER);
                if (cnt_reg < COUNT_CAP)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (!seen_reg)
                begin
                    seen_next  = 1'b1;
                    first_next = pos_reg - POS_W'(WIN - 1);
                end
            end
            else if (full_win && (skip_reg != '0))
            begin
                skip_next = skip_reg - 1'b1;
            end
            if (pos_reg < POS_CAP)
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            skip_reg  <= '0;
            cnt_reg   <= '0;
            first_reg <= '0;
            seen_reg  <= 1'b0;
        end
        else if (in_fire && s_tlast)
        begin
            // end of buffer: back to the start state for the next one
            pos_reg   <= '0;
            skip_reg  <= '0;
            cnt_reg   <= '0;
            first_reg <= '0;
            seen_reg  <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            skip_reg  <= skip_next;
            cnt_reg   <= cnt_next;
            first_reg <= first_next;
            seen_reg  <= seen_next;
        end
    end

    // snapshot of the statistics at the tlast beat
    always_ff @(posedge clk)
    begin
        if (in_fire && s_tlast)
        begin
            st_cnt_reg   <= cnt_next;
            st_first_reg <= first_next;
            st_found_reg <= seen_next;
        end
    end

    qprs_drain u_drain (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (in_fire && s_tlast),
        .load_bytes (cell_nxt),
        .load_cnt   (flush_cnt),
        .pop        (drain_pop),
        .head_byte  (drain_head),
        .stat       (drain_stat)
    );

    // output register: fed by a streaming beat or by the drain row, never both
    assign drain_pop = out_free && !drain_stat.empty;

    always_comb
    begin
        ovld_next   = ovld_reg && !m_tready;
        obyte_next  = obyte_reg;
        olast_next  = olast_reg;
        ocnt_next   = ocnt_reg;
        ofirst_next = ofirst_reg;
        ofound_next = ofound_reg;
        if (in_fire && !s_tlast && full_win)
        begin
            ovld_next   = 1'b1;
            obyte_next  = cell_nxt[0];
            olast_next  = 1'b0;
            ocnt_next   = '0;
            ofirst_next = '0;
            ofound_next = 1'b0;
        end
        else if (drain_pop)
        begin
            ovld_next   = 1'b1;
            obyte_next  = drain_head;
            olast_next  = drain_stat.head_last;
            ocnt_next   = drain_stat.head_last ? st_cnt_reg : '0;
            ofirst_next = drain_stat.head_last ? st_first_reg : '0;
            ofound_next = drain_stat.head_last && st_found_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovld_reg <= 1'b0;
        end
        else
        begin
            ovld_reg <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        obyte_reg  <= obyte_next;
        olast_reg  <= olast_next;
        ocnt_reg   <= ocnt_next;
        ofirst_reg <= ofirst_next;
        ofound_reg <= ofound_next;
    end

    assign m_tvalid = ovld_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {1'b0, ofound_reg, ofirst_reg, ocnt_reg, obyte_reg};

    // checks

    // skipping only ever follows a compare on a full window
    a_skip_full: assert property (@(posedge clk) disable iff (!rst_n)
        (skip_reg != '0) |-> (pos_reg >= POS_W'(WIN - 1)))
        else $error("skip count set before the window filled");

    // a nonzero replacement count means a first offset was recorded
    a_cnt_seen: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0) |-> seen_reg)
        else $error("replacement counted without first match");

    // a tlast beat always leaves bytes in the drain row
    a_flush_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_tlast) |=> !drain_stat.empty)
        else $error("end of buffer did not load the drain row");

    // statistics appear only on the final byte of a buffer
    a_stats_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> (m_tdata[38:8] == '0))
        else $error("statistics on a byte that is not last");

    // offset is zero unless a match was found
    a_offset_found: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[38]) |-> (m_tdata[37:22] == '0))
        else $error("first offset without a match");

endmodule

// ===== verif/qword_pattern_replace_scanner_top_tb.sv =====
// qword_pattern_replace_scanner_top_tb: self-checking bench for the 64-bit pattern replace scanner
// depends on qprs_pkg and qword_pattern_replace_scanner_top; needs no files or arguments
`timescale 1ns / 1ps

// Stimulus runs in two parts:
//   - a directed table of short buffers (single byte, short buffer, final window match,
//     overlapping matches), some rows carrying a typed-in end-of-buffer summary
//   - random buffers over several register settings, built mostly from whole and
//     partial copies of match_word mixed with random bytes; one phase runs with
//     no idling on either side
// Every accepted input beat goes through a bit-accurate window predictor that queues
// the output beats it causes; the output monitor checks each accepted beat against
// the oldest queued one.

module qword_pattern_replace_scanner_top_tb;
    import qprs_pkg::*;

    // position ceiling of the default build: the smaller of MAX_LEN-1 and 16 bits
    localparam int POS_LIMIT = (MAX_LEN_DEF - 1 < 65535) ? MAX_LEN_DEF - 1 : 65535;
    localparam int DIR_N = 25;
    localparam int RAND_ITEMS = 380;
    localparam int PHASE_ITEMS = 70;
    localparam int BURST_PHASE = 3;         // phase run with no idling at all
    localparam int IDLE_GAP = 16;           // drain margin before a register write
    localparam longint LIMIT_NS = 64'd18_000_000;

    // one output beat as the block reports it
    typedef struct packed {
        byte_t            data;
        logic             last;
        logic [CNT_W-1:0] total;
        logic [POS_W-1:0] offset;
        logic             found;
    } scan_beat_t;

    // one row of the directed table; total/found/offset only count where chk is set
    typedef struct packed {
        byte_t            data;
        logic             last;
        logic             reprogram;    // program match all ones, replacement zero first
        logic             chk;          // summary of the final beat is typed in
        logic [CNT_W-1:0] total;
        logic             found;
        logic [POS_W-1:0] offset;
    } dir_row_t;

    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        // single byte right after reset: passes through, nothing found
        '{8'hFF, 1'b1, 1'b0, 1'b1, 14'd0, 1'b0, 16'd0},
        // seven byte buffer: never compared, flushed unchanged on tlast
        '{8'h00, 1'b0, 1'b0, 1'b0, 14'd0, 1'b0, 16'd0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 14'd0, 1'b0, 16'd0},
        '{8'h01, 1'b0, 1'b0, 1'b0, 14'd0, 1'b0, 16'd0},
        '{8'h80, 1'b0, 1'b0, 1'b0, 14'd0, 1'b0, 16'd0},
        '{8'h7F, 1'b0, 1'b0, 1'b0, 14'd0, 1'b0, 16'd0},
        '{8'hFE, 1'b0, 1'b0, 1'b0, 14'd0, 1'b0, 16'd0},
        '{8'h55, 1'b1, 1'b0, 1'b1, 14'd0, 1'b0, 16'd0},
        // eight zeros against the reset pattern: the window ending on tlast matches
        '{8'h00, 1'b0, 1'b0, 1'b0, 14'd0, 1'b0, 16'd0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 14'd0, 1'b0, 16'd0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 14'd0, 1'b0, 16'd0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 14'd0, 1'b0, 16'd0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 14'd0, 1'b0, 16'd0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 14'd0, 1'b0, 16'd0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 14'd0, 1'b0, 16'd0},
        '{8'h00, 1'b1, 1'b0, 1'b1, 14'd1, 1'b1, 16'd0},
        // nine 0xFF against an all-ones pattern: second window overlaps, so one hit
        '{8'hFF, 1'b0, 1'b1, 1'b0, 14'd0, 1'b0, 16'd0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 14'd0, 1'b0, 16'd0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 14'd0, 1'b0, 16'd0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 14'd0, 1'b0, 16'd0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 14'd0, 1'b0, 16'd0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 14'd0, 1'b0, 16'd0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 14'd0, 1'b0, 16'd0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 14'd0, 1'b0, 16'd0},
        '{8'hFF, 1'b1, 1'b0, 1'b1, 14'd1, 1'b1, 16'd0}
    };

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]    cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = '0;     // [7:0] in_byte
    logic                 s_tlast = 1'b0;   // in_last
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [39:0]          m_tdata;          // [7:0] out_byte, [21:8] replaced_total,
                                            // [37:22] first_offset, [38] found, [39] zero
    logic                 m_tlast;          // out_last

    // predictor copy of the window state and registers
    byte_t             win [WIN];
    logic [SKIP_W-1:0] skip_run;
    logic [POS_W-1:0]  seen_len;
    logic [CNT_W-1:0]  hit_count;
    logic [POS_W-1:0]  first_hit;
    logic              hit_seen;
    logic [WORD_W-1:0] match_q;
    logic [WORD_W-1:0] repl_q;

    scan_beat_t due_bytes [$];      // output beats still owed by the block
    int         mismatch_cnt = 0;
    bit         gaps_on = 1'b1;     // random idling on both sides

    qword_pattern_replace_scanner_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // back to the start-of-buffer state; registers are kept
    function automatic void clear_scan();
        for (int k = 0; k < WIN; k++)
        begin
            win[k] = '0;
        end
        skip_run  = '0;
        seen_len  = '0;
        hit_count = '0;
        first_hit = '0;
        hit_seen  = 1'b0;
    endfunction

    // summary fields ride only on the final beat; offset and found only after a hit
    function automatic scan_beat_t make_beat(byte_t b, logic last);
        scan_beat_t r;
        r.data   = b;
        r.last   = last;
        r.total  = last ? hit_count : '0;
        r.offset = (last && hit_seen) ? first_hit : '0;
        r.found  = last && hit_seen;
        return r;
    endfunction

    // printable form of one output beat
    function automatic string beat_text(scan_beat_t b);
        return $sformatf("byte=%02h last=%0b total=%0d off=%0d found=%0b",
                         b.data, b.last, b.total, b.offset, b.found);
    endfunction

    // shift one byte into the window, compare and replace, queue the beats it frees
    function automatic void scan_byte(byte_t b, logic last);
        logic [POS_W-1:0]  n;
        logic [WORD_W-1:0] w;
        int                first;
        n = seen_len;
        for (int k = 0; k < WIN - 1; k++)
        begin
            win[k] = win[k + 1];
        end
        win[WIN - 1] = b;
        if (n >= WIN - 1)
        begin
            if (skip_run != 0)
            begin
                skip_run = skip_run - 1'b1;
            end
            else
            begin
                // oldest byte is the least significant one
                for (int k = 0; k < WIN; k++)
                begin
                    w[8*k +: 8] = win[k];
                end
                if (w == match_q)
                begin
                    for (int k = 0; k < WIN; k++)
                    begin
                        win[k] = repl_q[8*k +: 8];
                    end
                    if (hit_count != COUNT_CAP)
                    begin
                        hit_count = hit_count + 1'b1;
                    end
                    if (!hit_seen)
                    begin
                        hit_seen  = 1'b1;
                        first_hit = n - POS_W'(WIN - 1);
                    end
                    skip_run = SKIP_W'(SKIP_AFTER);
                end
            end
        end
        if (n < POS_LIMIT)
        begin
            seen_len = n + 1'b1;
        end
        if (!last)
        begin
            if (n >= WIN - 1)
            begin
                due_bytes.push_back(make_beat(win[0], 1'b0));
            end
        end
        else
        begin
            // flush: the whole window, or only what a short buffer holds
            first = (n >= WIN - 1) ? 0 : WIN - 1 - int'(n);
            for (int k = first; k < WIN; k++)
            begin
                due_bytes.push_back(make_beat(win[k], k == WIN - 1));
            end
            clear_scan();
        end
    endfunction

    // both registers, valid held high across the two beats
    task automatic write_words(input logic [WORD_W-1:0] pat, input logic [WORD_W-1:0] rep);
        for (int r = 0; r < 2; r++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= (r == 0) ? REG_MATCH_WORD : REG_REPLACEMENT_WORD;
            cfg_data  <= (r == 0) ? pat : rep;
            do
                @(posedge clk);
            while (!cfg_ready);
            if (r == 0)
                match_q = pat;
            else
                repl_q = rep;
        end
        cfg_valid <= 1'b0;
    endtask

    // one input beat, with an occasional random gap ahead of it
    task automatic feed_byte(input byte_t b, input logic last);
        if (gaps_on && $urandom_range(99, 0) < 17)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        scan_byte(b, last);
    endtask

    // hold the input until every owed beat is out and the block has settled
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (due_bytes.size() != 0)
            @(posedge clk);
        repeat (IDLE_GAP) @(posedge clk);
    endtask

    // output side stalls at random while gaps are on
    always @(posedge clk)
    begin
        m_tready <= !gaps_on || ($urandom_range(99, 0) >= 17);
    end

    // output checker: handshake values are the ones present just before the edge
    always @(posedge clk)
    begin : watch_out
        scan_beat_t got;
        scan_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.data   = m_tdata[7:0];
            got.last   = m_tlast;
            got.total  = m_tdata[21:8];
            got.offset = m_tdata[37:22];
            got.found  = m_tdata[38];
            if (due_bytes.size() == 0)
            begin
                mismatch_cnt++;
                $display("%0t: unexpected out beat exp none got %s", $time, beat_text(got));
            end
            else
            begin
                want = due_bytes.pop_front();
                if (got.data !== want.data || got.last !== want.last ||
                    got.total !== want.total || got.offset !== want.offset ||
                    got.found !== want.found)
                begin
                    mismatch_cnt++;
                    $display("%0t: out beat mismatch exp %s got %s",
                             $time, beat_text(want), beat_text(got));
                end
            end
        end
    end

    initial
    begin : stimulus
        dir_row_t          row;
        scan_beat_t        tail;
        byte_t             frame [$];
        logic [WORD_W-1:0] pat;
        logic [WORD_W-1:0] rep;
        int                rand_items;
        int                phase_items;
        int                len;
        int                pick;
        int                cut;
        int                ph;

        // predictor starts from the register and stream reset values
        match_q = '0;
        repl_q  = '0;
        clear_scan();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table; typed summaries replace the predicted one on the final beat
        for (int i = 0; i < DIR_N; i++)
        begin
            row = DIR_ROWS[i];
            if (row.reprogram)
            begin
                wait_idle();
                write_words('1, '0);
            end
            feed_byte(row.data, row.last);
            if (row.chk)
            begin
                tail = due_bytes.pop_back();
                tail.total  = row.total;
                tail.found  = row.found;
                tail.offset = row.offset;
                due_bytes.push_back(tail);
            end
        end
        wait_idle();

        // random buffers, register setting changed between phases with the block idle
        rand_items = 0;
        ph = 0;
        while (rand_items < RAND_ITEMS)
        begin
            case (ph % 6)
                0: begin pat = '0; rep = '1; end
                1: begin pat = '1; rep = {$urandom, $urandom}; end
                2: begin pat = {$urandom, $urandom}; rep = '0; end
                default: begin pat = {$urandom, $urandom}; rep = {$urandom, $urandom}; end
            endcase
            // one long stretch with no idling on either side
            gaps_on = (ph != BURST_PHASE);
            write_words(pat, rep);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS && rand_items + phase_items < RAND_ITEMS)
            begin
                // mostly medium buffers, now and then one too short to compare
                if ($urandom_range(7, 0) == 0)
                    len = $urandom_range(7, 1);
                else
                    len = $urandom_range(32, 8);
                frame.delete();
                while (frame.size() < len)
                begin
                    pick = $urandom_range(99, 0);
                    if (pick < 22)
                        cut = WIN;                      // whole pattern
                    else if (pick < 34)
                        cut = $urandom_range(7, 1);     // broken pattern prefix
                    else
                        cut = 0;
                    for (int k = 0; k < cut; k++)
                    begin
                        frame.push_back(pat[8*k +: 8]);
                    end
                    if (cut == 0)
                        frame.push_back(byte_t'($urandom));
                end
                for (int i = 0; i < frame.size(); i++)
                begin
                    feed_byte(frame[i], i == frame.size() - 1);
                end
                phase_items += frame.size();
            end
            rand_items += phase_items;
            ph++;
            wait_idle();
        end
        gaps_on = 1'b1;

        s_tvalid <= 1'b0;
        while (due_bytes.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatch_cnt == 0 && due_bytes.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog, several times the slowest correct run
    initial
    begin
        #(LIMIT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
